[rtl/core/fpos_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed predictor order select package
// Shared constants and the token that travels down the row of predictor cells.
// ----------------------------------------------------------------------------
package fpos_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_BLOCK   = 4096;
  localparam int ORDERS      = 5;
  localparam int ORD_BITS    = 3;
  localparam int POS_BITS    = 3;
  localparam int DIFF_BITS   = SAMPLE_BITS + ORDERS;
  localparam int SUM_BITS    = 40;

  localparam logic [POS_BITS-1:0] POS_MAX   = POS_BITS'(ORDERS - 1);
  localparam logic [ORD_BITS-1:0] ORD_LAST  = ORD_BITS'(ORDERS - 1);
  localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DIFF_BITS-1:0]   diff_t;
  typedef logic [SUM_BITS-1:0]           sum_t;
  typedef logic [ORD_BITS-1:0]           ord_t;
  typedef logic [POS_BITS-1:0]           pos_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    pos_t  pos;
    diff_t diff;
    sum_t  best_sum;
    ord_t  best_ord;
  } fpos_tok_t;

endpackage

[rtl/core/fpos_if.sv]
// ----------------------------------------------------------------------------
// Fixed predictor order select channels
// Valid/ready channels for the sample input and the order result.
// ----------------------------------------------------------------------------
interface fpos_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fpos_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    block_end;

  modport source (output valid, output sample, output block_end, input ready);
  modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface fpos_out_if;
  logic                             valid;
  logic                             ready;
  logic [fpos_pkg::ORD_BITS-1:0]    best_order;

  modport source (output valid, output best_order, input ready);
  modport sink   (input valid, input best_order, output ready);
endinterface

[rtl/core/fpos_cell.sv]
// ----------------------------------------------------------------------------
// Fixed predictor cell
// Forms one order of difference, accumulates its saturated absolute value and
// folds its sum into the running minimum at the end of a block.
// ----------------------------------------------------------------------------
module fpos_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  fpos_pkg::ord_t      ord,
  input  fpos_pkg::fpos_tok_t tok_in,
  output fpos_pkg::fpos_tok_t tok_out
);
  import fpos_pkg::*;

  fpos_tok_t             tok_r;
  fpos_tok_t             tok_nxt;
  diff_t                 prev_r;
  sum_t                  acc_r;
  sum_t                  acc_nxt;
  diff_t                 res;
  logic [DIFF_BITS-1:0]  res_mag;
  logic [SUM_BITS:0]     sum_ext;
  logic                  active;

  always_comb begin
    res     = (ord == '0) ? tok_in.diff : tok_in.diff - prev_r;
    res_mag = res[DIFF_BITS-1] ? DIFF_BITS'(-res) : DIFF_BITS'(res);
    sum_ext = {1'b0, acc_r} + (SUM_BITS+1)'(res_mag);
    active  = POS_BITS'(ord) <= tok_in.pos;
    if (!active) begin
      acc_nxt = acc_r;
    end else if (sum_ext[SUM_BITS]) begin
      acc_nxt = SUM_MAX;
    end else begin
      acc_nxt = sum_ext[SUM_BITS-1:0];
    end

    tok_nxt      = tok_in;
    tok_nxt.diff = res;
    if (tok_in.last && (acc_nxt < tok_in.best_sum)) begin
      tok_nxt.best_sum = acc_nxt;
      tok_nxt.best_ord = ord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_in.valid) begin
        acc_r <= tok_in.last ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_in.valid) begin
      prev_r <= tok_in.diff;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/core/fixed_predictor_order_select.sv]
// ----------------------------------------------------------------------------
// Fixed predictor order select
// Picks the fixed polynomial predictor order 0..4 with the least absolute
// residual sum over each block of audio samples.
// ----------------------------------------------------------------------------
// Usage: samples arrive on in_ch, one per transaction, with block_end set on
// the final sample of a block. Each sample walks down a row of five cells,
// one per predictor order; cell k forms the k-th difference from the output
// of cell k-1 and keeps its own 40-bit saturating sum. Order k counts only
// from the (k+1)th sample of a block. On the final sample every cell folds
// its sum into a running minimum (ties keep the lower order) and clears.
// Only a block_end transaction yields a result on out_ch.
// Throughput is one sample per cycle while out_ch does not stall. Each sample
// passes through the five cell registers of the row on its way to out_ch.
// A stall on out_ch freezes the whole row and drops in_ch.ready in the same
// cycle, so nothing is lost or repeated. Reset clears the sample position,
// the cell sums and all valid flags; the block takes input right after.
// ----------------------------------------------------------------------------
module fixed_predictor_order_select (
  input  logic clk,
  input  logic rst_n,
  fpos_in_if.sink    in_ch,
  fpos_out_if.source out_ch
);
  import fpos_pkg::*;

  fpos_tok_t tok [0:ORDERS];
  logic      adv;
  logic      in_acc;
  pos_t      pos_r;
  pos_t      pos_nxt;

  assign adv    = !out_ch.valid || out_ch.ready;
  assign in_acc = in_ch.valid && adv;

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_ch.block_end) begin
        pos_nxt = '0;
      end else if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    tok[0].valid    = in_ch.valid;
    tok[0].last     = in_ch.block_end;
    tok[0].pos      = pos_r;
    tok[0].diff     = DIFF_BITS'(in_ch.sample);
    tok[0].best_sum = SUM_MAX;
    tok[0].best_ord = '0;
  end

  for (genvar k = 0; k < ORDERS; k++) begin : g_cell
    fpos_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ord     (ORD_BITS'(k)),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign in_ch.ready       = adv;
  assign out_ch.valid      = tok[ORDERS].valid && tok[ORDERS].last;
  assign out_ch.best_order = tok[ORDERS].best_ord;

  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.best_order <= ORD_LAST)
    else $error("best_order out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("sample position beyond saturation");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.block_end) |=> pos_r == '0)
    else $error("sample position not cleared after final sample");

  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tok[ORDERS]))
    else $error("cell row moved during a stall");

endmodule

[verif/fpos_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed predictor order select checker
// Watches the sample and order channels. Each accepted sample is folded into
// a local copy of the five residual sums. A block_end sample queues the
// expected best order, and every order transaction is compared with the
// oldest queued order.
// ----------------------------------------------------------------------------
module fpos_checker
  import fpos_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fpos_in_if   in_mon,
  fpos_out_if  out_mon,
  output int   mismatches,
  output int   pending,
  output int   orders_checked
);

  sample_t recent [4];
  pos_t    depth_seen;
  sum_t    resid_sum [ORDERS];
  ord_t    order_queue [$];
  ord_t    want;
  logic    block_done;

  task automatic clear_block();
    for (int i = 0; i < 4; i++) recent[i] = '0;
    for (int k = 0; k < ORDERS; k++) resid_sum[k] = '0;
    depth_seen = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic fold_sample(input sample_t s, input logic last, output logic done,
                             output ord_t best);
    longint x, a, b, c, d;
    longint resid [ORDERS];
    longint unsigned grown;
    x = s;
    a = recent[0];
    b = recent[1];
    c = recent[2];
    d = recent[3];
    resid[0] = x;
    resid[1] = x - a;
    resid[2] = x - 2 * a + b;
    resid[3] = x - 3 * a + 3 * b - c;
    resid[4] = x - 4 * a + 6 * b - 4 * c + d;
    for (int k = 0; k < ORDERS; k++) begin
      if (k == 0 || int'(depth_seen) >= k) begin
        grown = longint'(resid_sum[k]) + ((resid[k] < 0) ? -resid[k] : resid[k]);
        resid_sum[k] = (grown > longint'(SUM_MAX)) ? SUM_MAX : sum_t'(grown);
      end
    end
    recent[3] = recent[2];
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = s;
    if (depth_seen < POS_MAX) depth_seen++;
    done = last;
    best = '0;
    if (last) begin
      for (int k = 1; k < ORDERS; k++) begin
        if (resid_sum[k] < resid_sum[best]) best = ord_t'(k);
      end
      clear_block();
    end
  endtask

  initial begin
    mismatches     = 0;
    pending        = 0;
    orders_checked = 0;
    clear_block();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_block();
      order_queue.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        fold_sample(in_mon.sample, in_mon.block_end, block_done, want);
        if (block_done) order_queue.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (order_queue.size() == 0) begin
          report_mismatch($sformatf("best_order %0d with no block pending",
                                    out_mon.best_order));
        end else begin
          want = order_queue.pop_front();
          orders_checked++;
          if (out_mon.best_order !== want) begin
            report_mismatch($sformatf("best_order mismatch: got %0d, expected %0d",
                                      out_mon.best_order, want));
          end
        end
      end
    end
    pending = order_queue.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed predictor order select testbench
// Drives blocks of audio samples into the order selector: a few short
// hand-built blocks, random blocks of noise, quiet signal, extremes and
// low-degree polynomials, and one long block of alternating extremes that
// drives the largest residuals into every order. Both channels idle at
// random in the first two of three phases and never in the third.
// ----------------------------------------------------------------------------
module tb;
  import fpos_pkg::*;

  localparam int RANDOM_SAMPLES = 1000;
  localparam int EXTREME_LEN    = 200;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam sample_t S_MAX = sample_t'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t S_MIN = ~S_MAX;

  typedef enum int {SHAPE_NOISE, SHAPE_POLY, SHAPE_QUIET, SHAPE_EXTREME} shape_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 25;
  int   recv_idle_pct = 45;
  int   samples_sent  = 0;
  int   blocks_sent   = 0;
  int   stall_cycles  = 0;
  int   mismatches;
  int   pending;
  int   orders_checked;

  fpos_in_if  in_ch ();
  fpos_out_if out_ch ();

  fixed_predictor_order_select u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fpos_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .orders_checked (orders_checked)
  );

  always #5 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", STALL_LIMIT);
      $display("fixed_predictor_order_select regression: fail");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.block_end <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    samples_sent++;
    if (last) blocks_sent++;
  endtask

  function automatic sample_t clamp_sample(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return sample_t'(v);
  endfunction

  function automatic longint rand_span(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_random_block();
    int     len;
    int     roll;
    int     noise;
    shape_e shape;
    longint c0, c1, c2, c3, v;
    sample_t s;
    roll = $urandom_range(99);
    if (roll < 60) len = $urandom_range(1, 12);
    else if (roll < 90) len = $urandom_range(13, 48);
    else len = $urandom_range(49, 200);
    shape = shape_e'($urandom_range(3));
    c0 = rand_span(1 << 20);
    c1 = ($urandom_range(3) > 0) ? rand_span(1 << 12) : 0;
    c2 = ($urandom_range(2) > 0) ? rand_span(1 << 6) : 0;
    c3 = ($urandom_range(1) > 0) ? rand_span(4) : 0;
    noise = ($urandom_range(1) > 0) ? $urandom_range(0, 3) : 0;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE: begin
          s = sample_t'($urandom);
        end
        SHAPE_POLY: begin
          v = c0 + c1 * i + c2 * i * i + c3 * i * i * i + rand_span(noise);
          s = clamp_sample(v);
        end
        SHAPE_QUIET: begin
          s = sample_t'(rand_span(8));
        end
        default: begin
          case ($urandom_range(3))
            0: s = S_MAX;
            1: s = S_MIN;
            2: s = '0;
            default: s = '1;
          endcase
        end
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin
    int phase_start;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.block_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 25 : 0;
      if (phase == 0) begin
        send_sample('0, 1'b1);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        for (int i = 1; i <= 3; i++) send_sample(sample_t'(i), i == 3);
        for (int i = 0; i < 6; i++) send_sample(sample_t'(5), i == 5);
        for (int i = 0; i < 6; i++) send_sample(sample_t'(i * i * i), i == 5);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? S_MAX : S_MIN, i == 5);
      end
      if (phase == 2) begin
        // Alternating extremes give the largest residual of every order, so
        // the high-order sums grow fastest and order 0 must still win.
        for (int i = 0; i < EXTREME_LEN; i++) begin
          send_sample(i[0] ? S_MAX : S_MIN, i == EXTREME_LEN - 1);
        end
      end
      phase_start = samples_sent;
      while (samples_sent - phase_start < RANDOM_SAMPLES / 3) send_random_block();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d blocks, one of %0d alternating full-scale samples.",
             samples_sent, blocks_sent, EXTREME_LEN);
    $display("Compared %0d best-order results over three idle patterns.", orders_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("fixed_predictor_order_select regression: pass");
    end else begin
      $display("fixed_predictor_order_select regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fpos_pkg.sv
rtl/core/fpos_if.sv
rtl/core/fpos_cell.sv
rtl/core/fixed_predictor_order_select.sv
verif/fpos_checker.sv
verif/tb.sv
